// ===== rtl/core/rtst_pkg.sv =====
package rtst_pkg;

  localparam int ANGLE_BITS_DEF = 32;
  localparam int CORDIC_STEPS   = 30;
  localparam int CS_W           = 34;
  localparam int DIV_W          = 63;
  localparam int Q_W            = 31;
  localparam int SQ_W           = 61;

  typedef logic signed [CS_W-1:0] cs_t;

  localparam cs_t CORDIC_GAIN = 34'sd652032874;
  localparam logic [31:0] ALT_RESET_32 = 32'd4288206305;

  localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10680862, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722,
    32'd20861, 32'd10430, 32'd5215, 32'd2608, 32'd1304,
    32'd652, 32'd326, 32'd163, 32'd81, 32'd41,
    32'd20, 32'd10, 32'd5, 32'd3, 32'd1
  };

  localparam logic [1:0] ST_RISES = 2'd0;
  localparam logic [1:0] ST_ABOVE = 2'd1;
  localparam logic [1:0] ST_BELOW = 2'd2;

  localparam logic [1:0] REG_LAT = 2'd0;
  localparam logic [1:0] REG_LON = 2'd1;
  localparam logic [1:0] REG_ALT = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic       zero_den;
    logic       neg;
  } ctrl_t;

  function automatic cs_t atan_cs(input int i);
    return $signed({{(CS_W-32){1'b0}}, ATAN_TURN[i]});
  endfunction

endpackage

// ===== rtl/core/rtst_sincos.sv =====
module rtst_sincos #(
  parameter int SB_W = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  logic [31:0]        in_ang [3],
  input  logic [SB_W-1:0]    in_side,
  output logic               out_vld,
  output rtst_pkg::cs_t      out_cos [3],
  output rtst_pkg::cs_t      out_sin [3],
  output logic [SB_W-1:0]    out_side
);

  localparam int N = rtst_pkg::CORDIC_STEPS;
  localparam int W = rtst_pkg::CS_W;

  rtst_pkg::cs_t x_r [N][3];
  rtst_pkg::cs_t y_r [N][3];
  rtst_pkg::cs_t z_r [N][3];
  logic          neg_r [N][3];
  logic [SB_W-1:0] side_r [N];
  logic          vld_r [N];

  rtst_pkg::cs_t z0 [3];
  logic          neg0 [3];

  // fold quadrants two and three onto the right half plane
  for (genvar l = 0; l < 3; l++) begin : g_fold
    logic [31:0] af;
    assign neg0[l] = (in_ang[l][31:30] == 2'd1) || (in_ang[l][31:30] == 2'd2);
    assign af = neg0[l] ? in_ang[l] + 32'h8000_0000 : in_ang[l];
    assign z0[l] = $signed({{(W-32){af[31]}}, af});
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    for (genvar l = 0; l < 3; l++) begin : g_lane
      rtst_pkg::cs_t xa, ya, za, x_nxt, y_nxt, z_nxt;
      logic          nega;
      if (i == 0) begin : g_first
        assign xa = rtst_pkg::CORDIC_GAIN;
        assign ya = '0;
        assign za = z0[l];
        assign nega = neg0[l];
      end else begin : g_next
        assign xa = x_r[i-1][l];
        assign ya = y_r[i-1][l];
        assign za = z_r[i-1][l];
        assign nega = neg_r[i-1][l];
      end
      assign x_nxt = !za[W-1] ? xa - (ya >>> i) : xa + (ya >>> i);
      assign y_nxt = !za[W-1] ? ya + (xa >>> i) : ya - (xa >>> i);
      assign z_nxt = !za[W-1] ? za - rtst_pkg::atan_cs(i) : za + rtst_pkg::atan_cs(i);
      always_ff @(posedge clk) begin
        if (en) begin
          x_r[i][l]   <= x_nxt;
          y_r[i][l]   <= y_nxt;
          z_r[i][l]   <= z_nxt;
          neg_r[i][l] <= nega;
        end
      end
    end

    if (i == 0) begin : g_c0
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= in_vld;
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[i] <= in_side;
        end
      end
    end else begin : g_cn
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (en) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
      always_ff @(posedge clk) begin
        if (en) begin
          side_r[i] <= side_r[i-1];
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_out
    assign out_cos[l] = neg_r[N-1][l] ? -x_r[N-1][l] : x_r[N-1][l];
    assign out_sin[l] = neg_r[N-1][l] ? -y_r[N-1][l] : y_r[N-1][l];
  end

  assign out_vld  = vld_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ===== rtl/core/rtst_div.sv =====
module rtst_div #(
  parameter int SB_W = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [rtst_pkg::DIV_W-1:0] in_n,
  input  logic [rtst_pkg::DIV_W-1:0] in_d,
  input  logic [SB_W-1:0]            in_side,
  output logic                       out_vld,
  output logic [rtst_pkg::Q_W-1:0]   out_q,
  output logic [SB_W-1:0]            out_side
);

  localparam int DW = rtst_pkg::DIV_W;
  localparam int QW = rtst_pkg::Q_W;
  localparam int NS = QW;

  logic [DW-1:0]   r_r [NS];
  logic [DW-1:0]   d_r [NS];
  logic [QW-1:0]   q_r [NS];
  logic [SB_W-1:0] side_r [NS];
  logic            vld_r [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [DW-1:0] r_nxt, d_nxt;
    logic [QW-1:0] q_nxt;
    logic [SB_W-1:0] side_nxt;
    logic vld_nxt;
    if (k == 0) begin : g_first
      logic ge;
      assign ge       = in_n >= in_d;
      assign r_nxt    = ge ? in_n - in_d : in_n;
      assign q_nxt    = {{(QW-1){1'b0}}, ge};
      assign d_nxt    = in_d;
      assign side_nxt = in_side;
      assign vld_nxt  = in_vld;
    end else begin : g_next
      logic [DW:0] r2, r2s;
      logic        ge;
      assign r2       = {r_r[k-1], 1'b0};
      assign ge       = r2 >= {1'b0, d_r[k-1]};
      assign r2s      = r2 - {1'b0, d_r[k-1]};
      assign r_nxt    = ge ? r2s[DW-1:0] : r2[DW-1:0];
      assign q_nxt    = {q_r[k-1][QW-2:0], ge};
      assign d_nxt    = d_r[k-1];
      assign side_nxt = side_r[k-1];
      assign vld_nxt  = vld_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_nxt;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]    <= r_nxt;
        d_r[k]    <= d_nxt;
        q_r[k]    <= q_nxt;
        side_r[k] <= side_nxt;
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_q    = q_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

// ===== rtl/core/rtst_isqrt.sv =====
module rtst_isqrt #(
  parameter int SB_W = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_vld,
  input  logic [rtst_pkg::SQ_W-1:0] in_v,
  input  logic [SB_W-1:0]           in_side,
  output logic                      out_vld,
  output logic [rtst_pkg::Q_W-1:0]  out_s,
  output logic [SB_W-1:0]           out_side
);

  localparam int RW = 62;
  localparam int NS = 31;

  logic [RW-1:0]   v_r [NS];
  logic [RW-1:0]   r_r [NS];
  logic [SB_W-1:0] side_r [NS];
  logic            vld_r [NS];

  // one result bit per stage, trial bit walks down from 2^60
  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam logic [RW-1:0] B = RW'(1) << (60 - 2 * k);
    logic [RW-1:0] va, ra, t, v_nxt, r_nxt;
    logic [SB_W-1:0] side_a;
    logic vld_a, ge;
    if (k == 0) begin : g_first
      assign va     = {{(RW-rtst_pkg::SQ_W){1'b0}}, in_v};
      assign ra     = '0;
      assign side_a = in_side;
      assign vld_a  = in_vld;
    end else begin : g_next
      assign va     = v_r[k-1];
      assign ra     = r_r[k-1];
      assign side_a = side_r[k-1];
      assign vld_a  = vld_r[k-1];
    end
    assign t     = ra + B;
    assign ge    = va >= t;
    assign v_nxt = ge ? va - t : va;
    assign r_nxt = ge ? (ra >> 1) + B : ra >> 1;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_a;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]    <= v_nxt;
        r_r[k]    <= r_nxt;
        side_r[k] <= side_a;
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_s    = r_r[NS-1][rtst_pkg::Q_W-1:0];
  assign out_side = side_r[NS-1];

endmodule

// ===== rtl/core/rtst_acos.sv =====
module rtst_acos #(
  parameter int SB_W = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic signed [31:0]       in_c,
  input  logic [rtst_pkg::Q_W-1:0] in_s,
  input  logic [SB_W-1:0]          in_side,
  output logic                     out_vld,
  output logic [31:0]              out_ang,
  output logic [SB_W-1:0]          out_side
);

  localparam int N = rtst_pkg::CORDIC_STEPS;
  localparam int W = rtst_pkg::CS_W;

  rtst_pkg::cs_t   x_r [N];
  rtst_pkg::cs_t   y_r [N];
  rtst_pkg::cs_t   z_r [N];
  logic [SB_W-1:0] side_r [N];
  logic            vld_r [N];

  rtst_pkg::cs_t c_e, s_e, x0, y0, z0;
  rtst_pkg::cs_t zf;

  assign c_e = $signed({{(W-32){in_c[31]}}, in_c});
  assign s_e = $signed({{(W-rtst_pkg::Q_W){1'b0}}, in_s});
  // negative cosine starts a quarter turn in
  assign x0  = in_c[31] ? s_e : c_e;
  assign y0  = in_c[31] ? -c_e : s_e;
  assign z0  = in_c[31] ? rtst_pkg::cs_t'(1) <<< 30 : '0;

  for (genvar i = 0; i < N; i++) begin : g_stage
    rtst_pkg::cs_t xa, ya, za, x_nxt, y_nxt, z_nxt;
    logic [SB_W-1:0] side_a;
    logic vld_a;
    if (i == 0) begin : g_first
      assign xa = x0;
      assign ya = y0;
      assign za = z0;
      assign side_a = in_side;
      assign vld_a  = in_vld;
    end else begin : g_next
      assign xa = x_r[i-1];
      assign ya = y_r[i-1];
      assign za = z_r[i-1];
      assign side_a = side_r[i-1];
      assign vld_a  = vld_r[i-1];
    end
    assign x_nxt = !ya[W-1] ? xa + (ya >>> i) : xa - (ya >>> i);
    assign y_nxt = !ya[W-1] ? ya - (xa >>> i) : ya + (xa >>> i);
    assign z_nxt = !ya[W-1] ? za + rtst_pkg::atan_cs(i) : za - rtst_pkg::atan_cs(i);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_a;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        side_r[i] <= side_a;
      end
    end
  end

  assign zf = z_r[N-1];

  always_comb begin
    if (zf[W-1]) begin
      out_ang = '0;
    end else if (zf > (rtst_pkg::cs_t'(1) <<< 31)) begin
      out_ang = 32'h8000_0000;
    end else begin
      out_ang = zf[31:0];
    end
  end

  assign out_vld  = vld_r[N-1];
  assign out_side = side_r[N-1];

endmodule

// ===== rtl/core/rise_transit_set_times.sv =====
// Rise, transit and set times of one body for a configured observer.
// Input channel (in_valid/in_ready): sidereal angle, right ascension and
// declination as binary angles, one full turn being 2^ANGLE_BITS.
// Result channel (out_valid/out_ready): rise, set and transit day
// fractions plus status (rises and sets, always above, always below);
// the three fractions are zero unless the body rises and sets.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 latitude,
// 1 east longitude, 2 standard altitude; other indexes are dropped.
// Write config only while no request is in flight.
// From input accept to result valid a request passes 30 sine/cosine
// CORDIC stages, 3 product stages, 31 divider stages, 2 square stages,
// 31 square-root stages, 30 arccosine CORDIC stages and the output register.
// Throughput is one request per cycle. The whole pipeline advances together;
// while a result sits unaccepted in the output register every stage holds,
// in_ready drops, and nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline and sets the registers
// to latitude 0, longitude 0 and altitude -0.5667 degrees.
module rise_transit_set_times #(
  parameter int ANGLE_BITS = rtst_pkg::ANGLE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [ANGLE_BITS-1:0]        in_sidereal_angle,
  input  logic [ANGLE_BITS-1:0]        in_right_ascension,
  input  logic signed [ANGLE_BITS-1:0] in_declination,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [ANGLE_BITS-1:0]        out_rise_fraction,
  output logic [ANGLE_BITS-1:0]        out_set_fraction,
  output logic [ANGLE_BITS-1:0]        out_transit_fraction,
  output logic [1:0]                   out_status,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic [ANGLE_BITS-1:0]        cfg_data
);

  localparam int AB  = ANGLE_BITS;
  localparam int W   = rtst_pkg::CS_W;
  localparam int DW  = rtst_pkg::DIV_W;
  localparam int QW  = rtst_pkg::Q_W;
  localparam int CW  = $bits(rtst_pkg::ctrl_t);
  localparam int SB1 = AB + CW;
  localparam int SB2 = AB + 2 + 32;
  localparam int SB3 = AB + 2;

  function automatic logic [31:0] to_t32(input logic [AB-1:0] a);
    logic [AB+31:0] t;
    t = {a, 32'd0};
    return t[AB+31 -: 32];
  endfunction

  function automatic logic [AB-1:0] from_t32(input logic [31:0] a);
    logic [AB+31:0] t;
    t = {a, {AB{1'b0}}};
    return t[AB+31 -: AB];
  endfunction

  logic [AB-1:0] lat_r, lon_r, alt_r;
  logic          adv;
  logic          out_valid_r;

  assign adv       = !out_valid_r || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= '0;
      lon_r <= '0;
      alt_r <= from_t32(rtst_pkg::ALT_RESET_32);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rtst_pkg::REG_LAT: lat_r <= cfg_data;
        rtst_pkg::REG_LON: lon_r <= cfg_data;
        rtst_pkg::REG_ALT: alt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sine and cosine of latitude, declination and altitude
  logic [31:0]     sc_ang [3];
  logic [AB-1:0]   tr_in;
  logic            sc_vld;
  rtst_pkg::cs_t   sc_cos [3];
  rtst_pkg::cs_t   sc_sin [3];
  logic [AB-1:0]   sc_tr;

  assign sc_ang[0] = to_t32(lat_r);
  assign sc_ang[1] = to_t32(in_declination);
  assign sc_ang[2] = to_t32(alt_r);
  assign tr_in     = in_right_ascension - lon_r - in_sidereal_angle;

  rtst_sincos #(.SB_W(AB)) u_sincos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (in_valid),
    .in_ang   (sc_ang),
    .in_side  (tr_in),
    .out_vld  (sc_vld),
    .out_cos  (sc_cos),
    .out_sin  (sc_sin),
    .out_side (sc_tr)
  );

  // products
  logic signed [2*W-1:0] ss_full, cc_full;
  logic signed [63:0]    m_ss_r, m_den_r;
  rtst_pkg::cs_t         m_sh_r;
  logic [AB-1:0]         m_tr_r;
  logic                  m_vld_r;

  assign ss_full = sc_sin[0] * sc_sin[1];
  assign cc_full = sc_cos[0] * sc_cos[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= sc_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ss_r  <= ss_full[63:0];
      m_den_r <= cc_full[63:0];
      m_sh_r  <= sc_sin[2];
      m_tr_r  <= sc_tr;
    end
  end

  // numerator, divisor made positive
  logic signed [63:0] sh64, num_t, n_num_nxt, n_den_nxt;
  logic signed [63:0] n_num_r, n_den_r;
  logic [AB-1:0]      n_tr_r;
  logic               n_vld_r;

  assign sh64  = $signed({{(64-W){m_sh_r[W-1]}}, m_sh_r}) <<< 30;
  assign num_t = sh64 - m_ss_r;

  always_comb begin
    if (m_den_r[63]) begin
      n_num_nxt = -num_t;
      n_den_nxt = -m_den_r;
    end else begin
      n_num_nxt = num_t;
      n_den_nxt = m_den_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_vld_r <= 1'b0;
    end else if (adv) begin
      n_vld_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_num_r <= n_num_nxt;
      n_den_r <= n_den_nxt;
      n_tr_r  <= m_tr_r;
    end
  end

  // circumpolar checks and magnitude for the divider
  rtst_pkg::ctrl_t    c_ctrl_nxt, c_ctrl_r;
  logic signed [63:0] num_mag;
  logic [DW-1:0]      c_n_r, c_d_r;
  logic [AB-1:0]      c_tr_r;
  logic               c_vld_r;

  assign num_mag = n_num_r[63] ? -n_num_r : n_num_r;

  always_comb begin
    c_ctrl_nxt.neg      = n_num_r[63];
    c_ctrl_nxt.zero_den = (n_den_r == 64'sd0);
    if (n_num_r < -n_den_r) begin
      c_ctrl_nxt.status = rtst_pkg::ST_ABOVE;
    end else if (n_num_r > n_den_r) begin
      c_ctrl_nxt.status = rtst_pkg::ST_BELOW;
    end else begin
      c_ctrl_nxt.status = rtst_pkg::ST_RISES;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_vld_r <= 1'b0;
    end else if (adv) begin
      c_vld_r <= n_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_ctrl_r <= c_ctrl_nxt;
      c_n_r    <= num_mag[DW-1:0];
      c_d_r    <= n_den_r[DW-1:0];
      c_tr_r   <= n_tr_r;
    end
  end

  // cosH0 = |num| / den in Q1.30
  logic            dv_vld;
  logic [QW-1:0]   dv_q;
  logic [SB1-1:0]  dv_side;
  rtst_pkg::ctrl_t dv_ctrl;
  logic [AB-1:0]   dv_tr;

  rtst_div #(.SB_W(SB1)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (c_vld_r),
    .in_n     (c_n_r),
    .in_d     (c_d_r),
    .in_side  ({c_ctrl_r, c_tr_r}),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_side (dv_side)
  );

  assign {dv_ctrl, dv_tr} = dv_side;

  // signed cosine, then 1 - c^2
  logic signed [31:0] s_c_nxt, s_c_r;
  logic [1:0]         s_st_r;
  logic [AB-1:0]      s_tr_r;
  logic               s_vld_r;

  always_comb begin
    if (dv_ctrl.zero_den) begin
      s_c_nxt = '0;
    end else if (dv_ctrl.neg) begin
      s_c_nxt = -$signed({1'b0, dv_q});
    end else begin
      s_c_nxt = $signed({1'b0, dv_q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_vld_r <= 1'b0;
    end else if (adv) begin
      s_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_c_r  <= s_c_nxt;
      s_st_r <= dv_ctrl.status;
      s_tr_r <= dv_tr;
    end
  end

  logic signed [63:0] csq, v_full;
  logic [rtst_pkg::SQ_W-1:0] q_v_r;
  logic signed [31:0] q_c_r;
  logic [1:0]         q_st_r;
  logic [AB-1:0]      q_tr_r;
  logic               q_vld_r;

  assign csq    = s_c_r * s_c_r;
  assign v_full = (64'sd1 <<< 60) - csq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else if (adv) begin
      q_vld_r <= s_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      q_v_r  <= v_full[rtst_pkg::SQ_W-1:0];
      q_c_r  <= s_c_r;
      q_st_r <= s_st_r;
      q_tr_r <= s_tr_r;
    end
  end

  // sine of the hour angle
  logic               sq_vld;
  logic [QW-1:0]      sq_s;
  logic [SB2-1:0]     sq_side;
  logic [1:0]         sq_st;
  logic signed [31:0] sq_c;
  logic [AB-1:0]      sq_tr;

  rtst_isqrt #(.SB_W(SB2)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (q_vld_r),
    .in_v     (q_v_r),
    .in_side  ({q_st_r, q_c_r, q_tr_r}),
    .out_vld  (sq_vld),
    .out_s    (sq_s),
    .out_side (sq_side)
  );

  assign {sq_st, sq_c, sq_tr} = sq_side;

  // hour angle in turns
  logic           ac_vld;
  logic [31:0]    ac_ang;
  logic [SB3-1:0] ac_side;
  logic [1:0]     ac_st;
  logic [AB-1:0]  ac_tr;
  logic [AB-1:0]  h;

  rtst_acos #(.SB_W(SB3)) u_acos (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (sq_vld),
    .in_c     (sq_c),
    .in_s     (sq_s),
    .in_side  ({sq_st, sq_tr}),
    .out_vld  (ac_vld),
    .out_ang  (ac_ang),
    .out_side (ac_side)
  );

  assign {ac_st, ac_tr} = ac_side;
  assign h = from_t32(ac_ang);

  // output register
  logic [AB-1:0] rise_r, set_r, tr_r;
  logic [1:0]    st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ac_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st_r <= ac_st;
      if (ac_st == rtst_pkg::ST_RISES) begin
        rise_r <= ac_tr - h;
        set_r  <= ac_tr + h;
        tr_r   <= ac_tr;
      end else begin
        rise_r <= '0;
        set_r  <= '0;
        tr_r   <= '0;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_rise_fraction    = rise_r;
  assign out_set_fraction     = set_r;
  assign out_transit_fraction = tr_r;
  assign out_status           = st_r;

endmodule

// ===== dv/rise_transit_set_times_tb.sv =====
`timescale 1ns / 1ps

module rise_transit_set_times_tb;

  localparam int          NPHASE      = 7;
  localparam int          NRAND       = 200;
  localparam int          IDLE_PCT    = 17;
  localparam int          HOLD_CYCLES = 400;
  localparam int          DRAIN_WAIT  = 200;
  localparam int          STUCK_LIMIT = 5000;
  localparam logic [1:0]  REG_NONE    = 2'd3;
  localparam logic [31:0] QUARTER     = 32'h4000_0000;
  localparam logic [31:0] MINUS_Q     = 32'hC000_0000;

  typedef struct {
    logic [31:0] sid;
    logic [31:0] ra;
    logic [31:0] dec;
  } body_req_t;

  typedef struct {
    logic [31:0] rise;
    logic [31:0] set_f;
    logic [31:0] transit;
    logic [1:0]  status;
  } times_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] in_sidereal_angle = '0;
  logic [31:0] in_right_ascension = '0;
  logic signed [31:0] in_declination = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] out_rise_fraction, out_set_fraction, out_transit_fraction;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  body_req_t pending_reqs[$];
  times_t    expected_times[$];
  logic [31:0] lat_q, lon_q, alt_q;
  bit idle_en;
  bit hold_req;
  bit hold_done;
  int hold_cnt;
  int errors;
  int stuck_cnt;

  rise_transit_set_times i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sidereal_angle   (in_sidereal_angle),
    .in_right_ascension  (in_right_ascension),
    .in_declination      (in_declination),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_rise_fraction   (out_rise_fraction),
    .out_set_fraction    (out_set_fraction),
    .out_transit_fraction(out_transit_fraction),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always #4 clk = ~clk;

  function automatic void sin_cos(input logic [31:0] a, output longint c, output longint s);
    logic [31:0] aa;
    bit neg;
    longint x, y, z, nx;
    neg = (a[31:30] == 2'd1) || (a[31:30] == 2'd2);
    aa = neg ? a + 32'h8000_0000 : a;
    z = longint'($signed(aa));
    x = longint'(rtst_pkg::CORDIC_GAIN);
    y = 0;
    for (int i = 0; i < rtst_pkg::CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - longint'(rtst_pkg::ATAN_TURN[i]);
      end else begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + longint'(rtst_pkg::ATAN_TURN[i]);
      end
      x = nx;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [31:0] half_arc(input longint c);
    longint s, x, y, z, nx;
    s = longint'(int_sqrt(64'(longint'(1) <<< 60) - 64'(c * c)));
    if (c < 0) begin
      x = s; y = -c; z = longint'(1) <<< 30;
    end else begin
      x = c; y = s; z = 0;
    end
    for (int i = 0; i < rtst_pkg::CORDIC_STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i); y = y - (x >>> i); z = z + longint'(rtst_pkg::ATAN_TURN[i]);
      end else begin
        nx = x - (y >>> i); y = y + (x >>> i); z = z - longint'(rtst_pkg::ATAN_TURN[i]);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > (longint'(1) <<< 31)) z = longint'(1) <<< 31;
    return z[31:0];
  endfunction

  function automatic longint ratio_q30(input logic [63:0] n, input logic [63:0] d);
    logic [63:0] q, r;
    q = (n >= d) ? 64'd1 : 64'd0;
    r = n - q * d;
    for (int i = 0; i < 30; i++) begin
      r = r << 1; q = q << 1;
      if (r >= d) begin
        r = r - d; q[0] = 1'b1;
      end
    end
    return longint'(q);
  endfunction

  function automatic times_t predict_times(input body_req_t b);
    times_t t;
    longint cl, sl, cd, sd, ch, sh, num, den, cosh, q;
    logic [31:0] h, tr;
    sin_cos(lat_q, cl, sl);
    sin_cos(b.dec, cd, sd);
    sin_cos(alt_q, ch, sh);
    num = sh * (longint'(1) <<< 30) - sl * sd;
    den = cl * cd;
    if (den < 0) begin
      den = -den; num = -num;
    end
    t = '{rise: '0, set_f: '0, transit: '0, status: rtst_pkg::ST_RISES};
    if (num < -den) begin
      t.status = rtst_pkg::ST_ABOVE;
    end else if (num > den) begin
      t.status = rtst_pkg::ST_BELOW;
    end else begin
      if (den == 0) cosh = 0;
      else begin
        q = ratio_q30(64'(num < 0 ? -num : num), 64'(den));
        cosh = (num < 0) ? -q : q;
      end
      h = half_arc(cosh);
      tr = b.ra - lon_q - b.sid;
      t.rise = tr - h;
      t.set_f = tr + h;
      t.transit = tr;
    end
    return t;
  endfunction

  function automatic logic [31:0] rand_signed_angle();
    return $urandom_range(32'h8000_0000, 0) - QUARTER;
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      rtst_pkg::REG_LAT: lat_q = val;
      rtst_pkg::REG_LON: lon_q = val;
      rtst_pkg::REG_ALT: alt_q = val;
      default: ;
    endcase
  endtask

  task automatic push_corner_bodies();
    pending_reqs.push_back('{32'h0, 32'h0, 32'h0});
    pending_reqs.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, QUARTER});
    pending_reqs.push_back('{32'hFFFF_FFFF, 32'h0, MINUS_Q});
    pending_reqs.push_back('{32'h0, 32'hFFFF_FFFF, QUARTER});
    pending_reqs.push_back('{32'h8000_0000, 32'h7FFF_FFFF, 32'h3FFF_FFFF});
    pending_reqs.push_back('{32'h7FFF_FFFF, 32'h8000_0000, 32'hC000_0001});
    pending_reqs.push_back('{32'h1234_5678, 32'h1234_5678, lat_q});
    pending_reqs.push_back('{32'h0, 32'h4000_0000, -lat_q});
  endtask

  task automatic push_random_bodies(input int n);
    for (int k = 0; k < n; k++)
      pending_reqs.push_back('{$urandom(), $urandom(), rand_signed_angle()});
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_times.size() != 0 || in_valid)
      @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pending_reqs.size() != 0 && !(idle_en && $urandom_range(99, 0) < IDLE_PCT)) begin
        body_req_t b;
        b = pending_reqs.pop_front();
        in_valid           <= 1'b1;
        in_sidereal_angle  <= b.sid;
        in_right_ascension <= b.ra;
        in_declination     <= b.dec;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver, with one long hold-off to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_cnt = hold_cnt + 1;
      if (hold_cnt >= HOLD_CYCLES) hold_done = 1'b1;
    end else begin
      out_ready <= !(idle_en && $urandom_range(99, 0) < IDLE_PCT);
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        expected_times.push_back(predict_times('{in_sidereal_angle, in_right_ascension,
                                                 in_declination}));
      if (out_valid && out_ready) begin
        if (expected_times.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          times_t e;
          e = expected_times.pop_front();
          if (out_status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, out_status); errors++;
          end
          if (out_rise_fraction !== e.rise) begin
            $error("rise_fraction expected %h actual %h", e.rise, out_rise_fraction);
            errors++;
          end
          if (out_set_fraction !== e.set_f) begin
            $error("set_fraction expected %h actual %h", e.set_f, out_set_fraction);
            errors++;
          end
          if (out_transit_fraction !== e.transit) begin
            $error("transit_fraction expected %h actual %h", e.transit, out_transit_fraction);
            errors++;
          end
        end
      end
    end
  end

  // watchdog on lack of progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      stuck_cnt = 0;
    else
      stuck_cnt = stuck_cnt + 1;
    if (stuck_cnt >= STUCK_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    lat_q = 32'h0;
    lon_q = 32'h0;
    alt_q = rtst_pkg::ALT_RESET_32;
    idle_en = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NPHASE; p++) begin
      case (p)
        0: ;
        1: begin
          write_reg(rtst_pkg::REG_LAT, QUARTER);
          write_reg(rtst_pkg::REG_LON, 32'hFFFF_FFFF);
          write_reg(rtst_pkg::REG_ALT, QUARTER);
          write_reg(REG_NONE, 32'hDEAD_BEEF);
        end
        2: begin
          write_reg(rtst_pkg::REG_LAT, MINUS_Q);
          write_reg(rtst_pkg::REG_LON, 32'h0);
          write_reg(rtst_pkg::REG_ALT, MINUS_Q);
        end
        3: begin
          // about 52 degrees north, standard altitude back at its default
          write_reg(rtst_pkg::REG_LAT, 32'h24FA_4FA5);
          write_reg(rtst_pkg::REG_LON, $urandom());
          write_reg(rtst_pkg::REG_ALT, rtst_pkg::ALT_RESET_32);
        end
        default: begin
          write_reg(rtst_pkg::REG_LAT, rand_signed_angle());
          write_reg(rtst_pkg::REG_LON, $urandom());
          write_reg(rtst_pkg::REG_ALT, $urandom_range(32'h0100_0000, 0) - 32'h0080_0000);
        end
      endcase
      idle_en = (p != 4);
      if (p == 5) hold_req = 1'b1;
      if (p <= 2) push_corner_bodies();
      if (p == 3) begin
        // sender stops until everything in flight has come back
        push_random_bodies(NRAND / 2);
        wait_drained();
        push_random_bodies(NRAND / 2);
      end else begin
        push_random_bodies(NRAND);
      end
      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clk);
    end
    if (expected_times.size() != 0) begin
      $error("%0d results never arrived", expected_times.size());
      errors++;
    end
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
